### rtl/core/mrc_pkg.sv
// ============================================================================
// mrc_pkg
// Shared widths, register indexes, reset values and the item flags used by
// the marked rectangle counter.
// ============================================================================
`default_nettype none

package mrc_pkg;

    // Field widths fixed by the block's interface
    localparam int LETTER_W    = 5;
    localparam int MASK_W      = 5;
    localparam int SIDE_CFG_W  = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int HEIGHT_W    = 11;
    localparam int COUNT_W     = 39;

    // Saturation value of a column run height
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LETTER_MASK = 1'b1;

    // Configuration reset values
    localparam logic [SIDE_CFG_W-1:0] SIDE_LENGTH_RESET = 11'd1;
    localparam logic [MASK_W-1:0]     LETTER_MASK_RESET = 5'd31;

    // Default sizing
    localparam int DEFAULT_MAX_SIDE = 1024;
    localparam int QUEUE_DEPTH      = 4;

    // Position flags of a classified cell
    typedef struct packed {
        logic row_end;
        logic grid_end;
    } mrc_flags_t;

    localparam int FLAGS_W = $bits(mrc_flags_t);

endpackage

`default_nettype wire

### rtl/core/mrc_front.sv
// ============================================================================
// mrc_front
// Accepts cells, tracks row and column position, updates the per-column run
// height of unmarked cells and hands each classified cell to the queue.
// ============================================================================
`default_nettype none

module mrc_front
    import mrc_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
    localparam int COL_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [SIDE_W-1:0]   eff_side,
    input  wire logic [MASK_W-1:0]   letter_mask,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [LETTER_W-1:0] s_cell_letters,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output logic [COL_W-1:0]         q_col,
    output logic [HEIGHT_W-1:0]      q_height,
    output mrc_flags_t               q_flags
);

    logic [COL_W-1:0]    col_reg, col_next;
    logic [COL_W-1:0]    row_reg, row_next;
    logic [SIDE_W-1:0]   fill_reg, fill_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [COL_W-1:0]    hold_col_reg;
    logic                hold_marked_reg;
    logic                hold_hit_reg;
    mrc_flags_t          hold_flags_reg;
    logic [HEIGHT_W-1:0] height_rd_reg;
    logic [HEIGHT_W-1:0] height_mem [MAX_SIDE];

    logic                accept;
    logic                push;
    logic                row_end;
    logic                grid_end;
    logic [SIDE_W-1:0]   col_plus1;
    logic [SIDE_W-1:0]   hold_col_plus1;
    logic [HEIGHT_W-1:0] height_base;
    logic [HEIGHT_W-1:0] height_new;

    // Take a cell only when the hold stage is free
    assign s_ready = !hold_valid_reg;
    assign accept  = s_valid && s_ready;
    assign push    = hold_valid_reg && q_ready;

    // Classify the position of the incoming cell
    assign col_plus1 = SIDE_W'(col_reg) + SIDE_W'(1);
    assign row_end   = (col_plus1 >= eff_side);
    assign grid_end  = row_end && ((SIDE_W'(row_reg) + SIDE_W'(1)) >= eff_side);

    // Advance the grid position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = grid_end ? '0 : (row_reg + COL_W'(1));
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Columns below the fill count hold a height written in this grid
    assign hold_col_plus1 = SIDE_W'(hold_col_reg) + SIDE_W'(1);

    always_comb begin
        fill_next = fill_reg;
        if (push) begin
            if (hold_flags_reg.grid_end) begin
                fill_next = '0;
            end else if (hold_col_plus1 > fill_reg) begin
                fill_next = hold_col_plus1;
            end
        end
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end
    end

    // New run height: zero on a marked cell, else one more, saturating
    assign height_base = hold_hit_reg ? height_rd_reg : '0;

    always_comb begin
        if (hold_marked_reg) begin
            height_new = '0;
        end else if (height_base == HEIGHT_MAX) begin
            height_new = HEIGHT_MAX;
        end else begin
            height_new = height_base + HEIGHT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            fill_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            fill_reg       <= fill_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture the cell's classification
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_col_reg    <= col_reg;
            hold_marked_reg <= |(s_cell_letters & letter_mask);
            hold_hit_reg    <= (SIDE_W'(col_reg) < fill_reg);
            hold_flags_reg  <= '{row_end: row_end, grid_end: grid_end};
        end
    end

    // Column height memory: read on accept, write back on push
    always_ff @(posedge aclk) begin
        if (accept) begin
            height_rd_reg <= height_mem[col_reg];
        end
        if (push) begin
            height_mem[hold_col_reg] <= height_new;
        end
    end

    assign q_valid  = hold_valid_reg;
    assign q_col    = hold_col_reg;
    assign q_height = height_new;
    assign q_flags  = hold_flags_reg;

endmodule

`default_nettype wire

### rtl/core/mrc_queue.sv
// ============================================================================
// mrc_queue
// Short first-in first-out queue between the front and the back end.
// ============================================================================
`default_nettype none

module mrc_queue
    import mrc_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Advance pointers with explicit wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_reg + PTR_W'(1));
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_reg + PTR_W'(1));
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mrc_back.sv
// ============================================================================
// mrc_back
// Runs the monotonic column stack over each row, accumulates the clear
// rectangle total and forms the marked rectangle count at each grid end.
// ============================================================================
`default_nettype none

module mrc_back
    import mrc_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
    localparam int COL_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [SIDE_W-1:0]   eff_side,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire logic [COL_W-1:0]    q_col,
    input  wire logic [HEIGHT_W-1:0] q_height,
    input  wire mrc_flags_t          q_flags,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [COUNT_W-1:0]       m_rect_count
);

    localparam int RUN_W  = HEIGHT_W + SIDE_W;
    localparam int ENT_W  = COL_W + HEIGHT_W + RUN_W;
    localparam int PAIR_W = 2 * SIDE_W + 1;
    localparam int TRI_W  = 2 * SIDE_W;
    localparam int FULL_W = 4 * SIDE_W;
    localparam int CMP_W  = (FULL_W > COUNT_W) ? FULL_W : COUNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_PUSH  = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_TRI   = 3'd5;
    localparam logic [2:0] ST_SQR   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [SIDE_W-1:0]   depth_reg, depth_next;
    logic [COUNT_W-1:0]  clear_reg, clear_next;
    logic                m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]  m_data_reg;

    logic [COL_W-1:0]    cur_col_reg;
    logic [HEIGHT_W-1:0] cur_h_reg;
    mrc_flags_t          cur_flags_reg;
    logic [COL_W-1:0]    top_col_reg, top_col_next;
    logic [HEIGHT_W-1:0] top_h_reg, top_h_next;
    logic [RUN_W-1:0]    top_sum_reg, top_sum_next;
    logic [RUN_W-1:0]    prod_reg, prod_next;
    logic [RUN_W-1:0]    base_reg, base_next;
    logic [TRI_W-1:0]    tri_reg, tri_next;
    logic [FULL_W-1:0]   full_reg, full_next;

    logic [ENT_W-1:0]    stack_mem [MAX_SIDE];
    logic [ENT_W-1:0]    stack_rd_reg;

    logic                load_cur;
    logic                out_load;
    logic                stk_rd_en;
    logic                stk_wr_en;
    logic                pop_hit;
    logic [SIDE_W-1:0]   depth_m1;
    logic [SIDE_W-1:0]   depth_m2;
    logic [SIDE_W-1:0]   span;
    logic [PAIR_W-1:0]   pair;
    logic [CMP_W-1:0]    full_ext;
    logic [CMP_W-1:0]    clear_ext;
    logic [CMP_W-1:0]    diff;
    logic [COUNT_W-1:0]  result;

    assign depth_m1 = depth_reg - SIDE_W'(1);
    assign depth_m2 = depth_reg - SIDE_W'(2);
    assign pop_hit  = (depth_reg != '0) && (top_h_reg >= cur_h_reg);

    // Width of the new column's range back to the entry below it
    assign span = (depth_reg != '0) ? SIDE_W'(cur_col_reg - top_col_reg)
                                    : (SIDE_W'(cur_col_reg) + SIDE_W'(1));

    assign pair = PAIR_W'(eff_side) * (PAIR_W'(eff_side) + PAIR_W'(1));

    // Full rectangle count minus clear total, floored at zero
    assign full_ext  = CMP_W'(full_reg);
    assign clear_ext = CMP_W'(clear_reg);
    assign diff      = full_ext - clear_ext;
    assign result    = (full_ext > clear_ext) ? COUNT_W'(diff) : '0;

    // Sequence one cell: pop, multiply, push, accumulate; at a grid end, form the count
    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        clear_next   = clear_reg;
        top_col_next = top_col_reg;
        top_h_next   = top_h_reg;
        top_sum_next = top_sum_reg;
        prod_next    = prod_reg;
        base_next    = base_reg;
        tri_next     = tri_reg;
        full_next    = full_reg;
        load_cur     = 1'b0;
        out_load     = 1'b0;
        stk_rd_en    = 1'b0;
        stk_wr_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    load_cur   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (pop_hit) begin
                    depth_next = depth_m1;
                    if (depth_reg > SIDE_W'(1)) begin
                        stk_rd_en  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    prod_next  = RUN_W'(cur_h_reg) * RUN_W'(span);
                    base_next  = (depth_reg != '0) ? top_sum_reg : '0;
                    state_next = ST_PUSH;
                end
            end
            ST_LOAD: begin
                {top_col_next, top_h_next, top_sum_next} = stack_rd_reg;
                state_next = ST_CHECK;
            end
            ST_PUSH: begin
                stk_wr_en    = (depth_reg != '0);
                top_col_next = cur_col_reg;
                top_h_next   = cur_h_reg;
                top_sum_next = base_reg + prod_reg;
                depth_next   = depth_reg + SIDE_W'(1);
                state_next   = ST_ACC;
            end
            ST_ACC: begin
                clear_next = clear_reg + COUNT_W'(top_sum_reg);
                if (cur_flags_reg.row_end) begin
                    depth_next = '0;
                end
                if (cur_flags_reg.grid_end) begin
                    state_next = ST_TRI;
                end else if (q_valid) begin
                    load_cur   = 1'b1;
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TRI: begin
                tri_next   = pair[PAIR_W-1:1];
                state_next = ST_SQR;
            end
            ST_SQR: begin
                full_next  = FULL_W'(tri_reg) * FULL_W'(tri_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    clear_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            clear_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            clear_reg   <= clear_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_cur) begin
            cur_col_reg   <= q_col;
            cur_h_reg     <= q_height;
            cur_flags_reg <= q_flags;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
        top_col_reg <= top_col_next;
        top_h_reg   <= top_h_next;
        top_sum_reg <= top_sum_next;
        prod_reg    <= prod_next;
        base_reg    <= base_next;
        tri_reg     <= tri_next;
        full_reg    <= full_next;
    end

    // Stack memory: entries below the top, top kept in registers
    always_ff @(posedge aclk) begin
        if (stk_rd_en) begin
            stack_rd_reg <= stack_mem[depth_m2[COL_W-1:0]];
        end
        if (stk_wr_en) begin
            stack_mem[depth_m1[COL_W-1:0]] <= {top_col_reg, top_h_reg, top_sum_reg};
        end
    end

    assign q_ready      = load_cur;
    assign m_valid      = m_valid_reg;
    assign m_rect_count = m_data_reg;

endmodule

`default_nettype wire

### rtl/core/marked_rectangle_counter.sv
// ============================================================================
// marked_rectangle_counter
// Counts the subrectangles of a square grid that hold at least one marked
// cell, from cells streamed in row-major order.
// ============================================================================
// Cells enter row by row; a cell is marked when its letter bits meet
// letter_mask. One result, the number of subrectangles holding a marked cell,
// follows the last cell of each side_length by side_length grid (side 0 acts
// as 1, sides above MAX_SIDE as MAX_SIDE). The front holds each cell while the
// column height memory is read and written back, and takes no new cell until
// the held one has gone to the queue. The back end steps each cell through
// check, push and accumulate states; each column popped from the monotonic
// stack adds check and load (check alone for the last entry), set by the
// registered read of the stack memory, and is popped at most once per push.
// A grid end passes through triangle, square and output states to form the
// full count. A four-deep queue lets the front run ahead of the back end, and
// an output register lets the next grid start while a result waits. Column
// heights need no clearing pass: a fill count marks which columns were written
// in the current grid. Configuration is written through cfg_we, cfg_index and
// cfg_wdata while the block is idle; the user keeps to this, the block does not.
// ============================================================================
`default_nettype none

module marked_rectangle_counter
    import mrc_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [LETTER_W-1:0]    s_cell_letters,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [COUNT_W-1:0]          m_rect_count
);

    localparam int COL_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int ITEM_W  = COL_W + HEIGHT_W + FLAGS_W;

    logic [SIDE_CFG_W-1:0] side_length_reg;
    logic [MASK_W-1:0]     letter_mask_reg;
    logic [SIDE_W-1:0]     eff_side;

    logic                  f_valid;
    logic                  f_ready;
    logic [COL_W-1:0]      f_col;
    logic [HEIGHT_W-1:0]   f_height;
    mrc_flags_t            f_flags;

    logic                  b_valid;
    logic                  b_ready;
    logic [COL_W-1:0]      b_col;
    logic [HEIGHT_W-1:0]   b_height;
    mrc_flags_t            b_flags;

    logic [ITEM_W-1:0]     push_item;
    logic [ITEM_W-1:0]     pop_item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_length_reg <= SIDE_LENGTH_RESET;
            letter_mask_reg <= LETTER_MASK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SIDE_LENGTH: side_length_reg <= cfg_wdata;
                REG_LETTER_MASK: letter_mask_reg <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the side into the supported range
    always_comb begin
        if (side_length_reg == '0) begin
            eff_side = SIDE_W'(1);
        end else if (32'(side_length_reg) > MAX_SIDE) begin
            eff_side = SIDE_W'(MAX_SIDE);
        end else begin
            eff_side = SIDE_W'(side_length_reg);
        end
    end

    mrc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .eff_side       (eff_side),
        .letter_mask    (letter_mask_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_letters (s_cell_letters),
        .q_valid        (f_valid),
        .q_ready        (f_ready),
        .q_col          (f_col),
        .q_height       (f_height),
        .q_flags        (f_flags)
    );

    assign push_item = {f_col, f_height, f_flags};

    mrc_queue #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (push_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (pop_item)
    );

    assign {b_col, b_height, b_flags} = pop_item;

    mrc_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .eff_side     (eff_side),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_col        (b_col),
        .q_height     (b_height),
        .q_flags      (b_flags),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rect_count (m_rect_count)
    );

    // The back end only takes a cell that the queue holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_ready |-> b_valid)
        else $error("back end took a cell from an empty queue");

    // The front only hands over a cell when the queue has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !f_ready |=> f_valid && $stable(f_col) && $stable(f_flags))
        else $error("front dropped or changed a cell while the queue was full");

    // A cell in the hold stage blocks the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front took a cell while still holding the previous one");

    // Reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire

### sim/rect_count_checker.sv
// ----------------------------------------------------------------------------
// rect_count_checker
// Watches the configuration port and both streams of the marked rectangle
// counter, keeps its own model of the column heights and the monotonic stack,
// and compares every returned rectangle count with the oldest predicted one.
// ----------------------------------------------------------------------------
module rect_count_checker
    import mrc_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [LETTER_W-1:0]    s_cell_letters,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [COUNT_W-1:0]     m_rect_count,
    output int                     fail_count,
    output int                     pending_count,
    output int                     cells_seen,
    output int                     grids_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_W = $clog2(MAX_SIDE);

    // Mirrored configuration
    logic [SIDE_CFG_W-1:0] side_reg;
    logic [MASK_W-1:0]     mask_reg;

    // Mirrored grid state
    logic [HEIGHT_W-1:0]   heights [MAX_SIDE];
    logic [COL_W-1:0]      stack_cols [MAX_SIDE];
    int unsigned           stack_fill;
    int unsigned           row_idx;
    int unsigned           col_idx;
    logic [COUNT_W-1:0]    clear_sum;
    longint unsigned       run_sum;

    logic [COUNT_W-1:0]    expected_counts [$];
    int                    mismatches = 0;
    int                    cell_total = 0;
    int                    grid_total = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        cells_seen    = 0;
        grids_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic clear_grid();
        foreach (heights[i])
            heights[i] = '0;
        stack_fill = 0;
        row_idx    = 0;
        col_idx    = 0;
        clear_sum  = '0;
        run_sum    = 0;
    endtask

    // Fold one cell into the grid state; queue a count at the grid end
    task automatic fold_cell(input logic [LETTER_W-1:0] letters);
        int unsigned        side;
        int unsigned        c;
        int unsigned        h;
        int unsigned        top;
        int unsigned        th;
        int unsigned        span;
        int unsigned        width;
        longint unsigned    pairs;
        longint unsigned    full;
        logic [COUNT_W-1:0] predicted;

        side = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
        c = col_idx % MAX_SIDE;

        // Extend or break the run of unmarked cells in this column
        if ((letters & mask_reg) != 0) begin
            h = 0;
        end else begin
            h = heights[c] + 1;
            if (h > HEIGHT_MAX)
                h = HEIGHT_MAX;
        end
        heights[c] = HEIGHT_W'(h);

        // Drop columns at least as tall as the new one
        while (stack_fill > 0) begin
            top = stack_cols[stack_fill - 1];
            th  = heights[top];
            if (th < h)
                break;
            stack_fill--;
            span = (stack_fill > 0) ? top - stack_cols[stack_fill - 1] : top + 1;
            run_sum = run_sum - 64'(th) * 64'(span);
        end
        width = (stack_fill > 0) ? c - stack_cols[stack_fill - 1] : c + 1;
        run_sum = run_sum + 64'(h) * 64'(width);
        if (stack_fill < MAX_SIDE) begin
            stack_cols[stack_fill] = COL_W'(c);
            stack_fill++;
        end
        clear_sum = clear_sum + run_sum[COUNT_W-1:0];

        if (c + 1 < side) begin
            col_idx = c + 1;
            return;
        end

        // Row end: empty the stack, advance the row or close the grid
        stack_fill = 0;
        run_sum    = 0;
        col_idx    = 0;
        if (row_idx + 1 < side) begin
            row_idx++;
            return;
        end
        pairs = 64'(side) * 64'(side + 1) / 2;
        full  = pairs * pairs;
        predicted = (full > clear_sum) ? COUNT_W'(full - clear_sum) : '0;
        expected_counts.push_back(predicted);
        clear_grid();
    endtask

    always @(posedge aclk) begin
        logic [COUNT_W-1:0] oldest;
        if (!aresetn) begin
            side_reg = SIDE_LENGTH_RESET;
            mask_reg = LETTER_MASK_RESET;
            clear_grid();
            expected_counts.delete();
        end else begin
            // Track register writes
            if (cfg_we) begin
                if (cfg_index == REG_SIDE_LENGTH)
                    side_reg = cfg_wdata[SIDE_CFG_W-1:0];
                else if (cfg_index == REG_LETTER_MASK)
                    mask_reg = cfg_wdata[MASK_W-1:0];
            end

            // Predict on each input transaction
            if (s_valid && s_ready) begin
                fold_cell(s_cell_letters);
                cell_total++;
            end

            // Compare each result transaction with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("rect_count %0d returned with none predicted",
                                              m_rect_count));
                end else begin
                    oldest = expected_counts.pop_front();
                    if (m_rect_count !== oldest)
                        report_mismatch($sformatf("rect_count got %0d, predicted %0d",
                                                  m_rect_count, oldest));
                    grid_total++;
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_counts.size();
        cells_seen    <= cell_total;
        grids_checked <= grid_total;
    end

endmodule

### sim/marked_rectangle_counter_tb.sv
// ----------------------------------------------------------------------------
// marked_rectangle_counter_tb
// Drives cells into the marked rectangle counter through a short directed
// sequence and then random grids of many sizes and masks, with random gaps,
// a long result stall, mid-grid register changes and one full-width row; the
// checker beside the block predicts and compares every rectangle count.
// ----------------------------------------------------------------------------
module marked_rectangle_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrc_pkg::*;

    localparam int MAX_SIDE     = DEFAULT_MAX_SIDE;
    localparam int ITEM_TARGET  = 1600;
    localparam int IDLE_PCT     = 22;
    localparam int DRAIN_CYCLES = 2500;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_we         = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = REG_SIDE_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata      = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [LETTER_W-1:0]    s_cell_letters = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [COUNT_W-1:0]     m_rect_count;

    int fail_count;
    int pending_count;
    int cells_seen;
    int grids_checked;

    bit no_idle      = 1'b0;
    bit hold_pending = 1'b0;
    int cells_sent   = 0;
    int phases       = 0;
    int cycle_count  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    marked_rectangle_counter #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_letters(s_cell_letters),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rect_count  (m_rect_count)
    );

    rect_count_checker #(
        .MAX_SIDE(MAX_SIDE)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_letters(s_cell_letters),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rect_count  (m_rect_count),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .cells_seen    (cells_seen),
        .grids_checked (grids_checked)
    );

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin
        int held;
        forever begin
            if (hold_pending) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge aclk);
                hold_pending = 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    function automatic int unsigned grid_side(input int unsigned side);
        if (side == 0)
            return 1;
        return (side > MAX_SIDE) ? MAX_SIDE : side;
    endfunction

    // Letters for one cell; mark_pct sets how often it meets the mask
    function automatic logic [LETTER_W-1:0] pick_letters(input logic [MASK_W-1:0] mask,
                                                         input int mark_pct);
        logic [LETTER_W-1:0] v;
        int                  b;
        v = LETTER_W'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 45)
            v = LETTER_W'(1) << $urandom_range(0, LETTER_W - 1);
        if ($urandom_range(0, 99) < 15)
            v = '0;
        if ($urandom_range(0, 99) < mark_pct) begin
            if ((v & mask) == 0 && mask != 0) begin
                b = $urandom_range(0, LETTER_W - 1);
                while (!mask[b])
                    b = (b + 1) % LETTER_W;
                v = LETTER_W'(1) << b;
            end
        end else begin
            v = v & ~mask;
        end
        return v;
    endfunction

    // Offer one cell and hold it until the transaction completes
    task automatic send_cell(input logic [LETTER_W-1:0] letters);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cell_letters <= letters;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        cells_sent++;
    endtask

    task automatic send_cells(input int count, input logic [MASK_W-1:0] mask,
                              input int mark_pct);
        repeat (count)
            send_cell(pick_letters(mask, mark_pct));
    endtask

    // Hold the input until every count is back and the block has settled
    task automatic pause_until_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned side, input logic [MASK_W-1:0] mask);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SIDE_LENGTH;
        cfg_wdata <= CFG_DATA_W'(side);
        @(posedge aclk);
        cfg_index <= REG_LETTER_MASK;
        cfg_wdata <= CFG_DATA_W'(mask);
        @(posedge aclk);
        cfg_we <= 1'b0;
        phases++;
    endtask

    initial begin
        int unsigned         side;
        logic [MASK_W-1:0]   mask;
        int                  mark_pct;
        int                  grids;
        int                  cells;
        int                  cut;
        int                  r;
        int                  stop_at;
        int                  pct_choices [5];
        bit                  stall_done;
        bit                  wide_done;

        pct_choices = '{0, 10, 30, 60, 100};
        stall_done  = 1'b0;
        wide_done   = 1'b0;

        repeat (10)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-cell grids: empty and fully lettered cell
        set_config(1, 5'b11111);
        send_cell(5'b00000);
        send_cell(5'b11111);

        // Side zero acts as one
        pause_until_idle();
        set_config(0, 5'b00001);
        send_cell(5'b00001);
        send_cell(5'b00010);

        // Empty mask: nothing is ever marked
        pause_until_idle();
        set_config(2, 5'b00000);
        repeat (4)
            send_cell(5'b11111);

        // Mixed grid with a sparse mask
        pause_until_idle();
        set_config(3, 5'b10101);
        send_cell(5'b00000);
        send_cell(5'b10000);
        send_cell(5'b01010);
        send_cell(5'b00001);
        send_cell(5'b00010);
        send_cell(5'b00100);
        send_cell(5'b01000);
        send_cell(5'b11111);
        send_cell(5'b00000);

        // Oversized side clamps; shrink it and change the mask mid-grid so the
        // clear total passes the full count and the result saturates
        pause_until_idle();
        set_config(2047, 5'b11111);
        repeat (5)
            send_cell(5'b00000);
        pause_until_idle();
        set_config(2, 5'b00010);
        send_cell(5'b00010);
        send_cell(5'b00000);
        send_cell(5'b00000);

        // Random grids
        stop_at = cells_sent + ITEM_TARGET;
        while (cells_sent < stop_at) begin
            pause_until_idle();
            no_idle = (phases >= 10 && phases < 16);

            r = $urandom_range(0, 99);
            if (r < 6)
                side = 0;
            else if (r < 12)
                side = 1;
            else if (r < 80)
                side = $urandom_range(2, 6);
            else if (r < 94)
                side = $urandom_range(7, 12);
            else
                side = $urandom_range(13, 20);
            r = $urandom_range(0, 99);
            if (r < 10)
                mask = '0;
            else if (r < 25)
                mask = '1;
            else
                mask = MASK_W'($urandom_range(0, 31));

            if (!stall_done && phases >= 8) begin
                // Stall results while one-cell grids keep arriving
                stall_done = 1'b1;
                set_config(1, 5'b11111);
                hold_pending = 1'b1;
                send_cells(40, 5'b11111, 50);
                continue;
            end
            if (!wide_done && phases >= 12) begin
                // One full-width row and a little of the next, then shrink
                wide_done = 1'b1;
                set_config(MAX_SIDE, 5'b01100);
                send_cells(MAX_SIDE + 6, 5'b01100, 10);
                pause_until_idle();
                set_config($urandom_range(1, 4), 5'b01100);
                send_cells(16, 5'b01100, 30);
                continue;
            end

            set_config(side, mask);
            grids = $urandom_range(1, 3);
            repeat (grids) begin
                mark_pct = pct_choices[$urandom_range(0, 4)];
                cells = grid_side(side) * grid_side(side);
                if (cells > 1 && $urandom_range(0, 99) < 12) begin
                    // Break the grid with a register change part way in
                    cut = $urandom_range(1, cells - 1);
                    send_cells(cut, mask, mark_pct);
                    pause_until_idle();
                    side = $urandom_range(0, 8);
                    mask = MASK_W'($urandom_range(0, 31));
                    set_config(side, mask);
                    cells = grid_side(side) * grid_side(side);
                end
                send_cells(cells, mask, mark_pct);
            end
        end

        pause_until_idle();
        $display("Covered %0d cells and %0d checked rectangle counts over %0d register settings,",
                 cells_seen, grids_checked, phases);
        $display("with side clamping, mid-grid changes, saturation, a full row and long stalls.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### marked_rectangle_counter.f
rtl/core/mrc_pkg.sv
rtl/core/mrc_front.sv
rtl/core/mrc_queue.sv
rtl/core/mrc_back.sv
rtl/core/marked_rectangle_counter.sv
sim/rect_count_checker.sv
sim/marked_rectangle_counter_tb.sv
